// ===== hw/rtl/frp_pkg.sv =====
// ----------------------------------------------------------------------------
// frp_pkg
// Types, constants and arithmetic helpers for the fisheye projection core.
// ----------------------------------------------------------------------------
package frp_pkg;

  localparam int MAX_TERMS_DEF = 16;
  localparam int CORDIC_STEPS  = 30;
  localparam int SQRT_STEPS    = 32;
  localparam int DIV_STEPS     = 31;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;

  // command codes
  localparam logic CMD_COEF = 1'b0;
  localparam logic CMD_RAY  = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AFFINE_C   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AFFINE_D   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AFFINE_E   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TERM_COUNT = 3'd5;

  // pipeline stage positions that do not depend on the term count
  localparam int K_SQ    = 1;
  localparam int K_SUM   = 2;
  localparam int K_SQRT0 = 3;
  localparam int K_PREP  = K_SQRT0 + SQRT_STEPS;
  localparam int K_NORM0 = K_PREP + 1;
  localparam int K_DIV0  = K_PREP + 1;
  localparam int K_DSGN  = K_DIV0 + DIV_STEPS;
  localparam int K_CORD0 = K_NORM0 + 3;
  localparam int K_THETA = K_CORD0 + CORDIC_STEPS;
  localparam int K_HORN0 = K_THETA + 1;

  typedef struct packed {
    logic               cmd;
    logic [3:0]         coef_index;
    logic signed [47:0] coef_value;
    logic signed [31:0] ray_x;
    logic signed [31:0] ray_y;
    logic signed [31:0] ray_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pixel_u;
    logic signed [31:0] pixel_v;
    logic               on_axis;
    logic               clipped;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] affine_c;
    logic signed [31:0] affine_d;
    logic signed [31:0] affine_e;
  } cfg_t;

  // partial products of a 50 x 32 multiply split at bit 24
  typedef struct packed {
    logic signed [57:0] ph;
    logic signed [56:0] pl;
  } pp_t;

  typedef struct packed {
    in_item_t           item;
    logic               on_axis;
    logic [62:0]        xx;
    logic [62:0]        yy;
    logic [63:0]        sqv;
    logic [35:0]        srem;
    logic [31:0]        sroot;
    logic [60:0]        nm;
    logic signed [63:0] cord_x;
    logic signed [63:0] cord_y;
    logic signed [31:0] ang;
    logic [61:0]        drx;
    logic [61:0]        dry;
    logic [30:0]        qx;
    logic [30:0]        qy;
    logic signed [31:0] ux;
    logic signed [31:0] uy;
    logic signed [31:0] theta;
    logic signed [47:0] rho;
    pp_t                p0;
    pp_t                p1;
    pp_t                p2;
    logic signed [49:0] px;
    logic signed [49:0] py;
    logic signed [53:0] su;
    logic signed [53:0] sv;
    logic               clip;
    out_item_t          res;
  } pipe_t;

  // atan(2^-i) in q2.30, truncated
  function automatic logic signed [31:0] atan_q30(input int i);
    logic signed [31:0] a;
    case (i)
      0:       a = 32'sd843314856;
      1:       a = 32'sd497837829;
      2:       a = 32'sd263043836;
      3:       a = 32'sd133525158;
      4:       a = 32'sd67021686;
      5:       a = 32'sd33543515;
      6:       a = 32'sd16775850;
      7:       a = 32'sd8388437;
      8:       a = 32'sd4194282;
      9:       a = 32'sd2097149;
      10:      a = 32'sd1048575;
      11:      a = 32'sd524287;
      12:      a = 32'sd262143;
      13:      a = 32'sd131071;
      14:      a = 32'sd65535;
      15:      a = 32'sd32767;
      16:      a = 32'sd16383;
      17:      a = 32'sd8191;
      18:      a = 32'sd4095;
      19:      a = 32'sd2047;
      20:      a = 32'sd1023;
      21:      a = 32'sd511;
      22:      a = 32'sd255;
      23:      a = 32'sd127;
      24:      a = 32'sd63;
      25:      a = 32'sd31;
      26:      a = 32'sd15;
      27:      a = 32'sd7;
      28:      a = 32'sd3;
      29:      a = 32'sd1;
      default: a = 32'sd0;
    endcase
    return a;
  endfunction

  function automatic pp_t mul_split(input logic signed [49:0] a,
                                    input logic signed [31:0] b);
    pp_t                p;
    logic signed [25:0] ah;
    logic signed [24:0] al;
    ah   = 26'(a >>> 24);
    al   = $signed({1'b0, a[23:0]});
    p.ph = ah * b;
    p.pl = al * b;
    return p;
  endfunction

  // floor(a * b / 2^30) from the partial products
  function automatic logic signed [51:0] mul_join(input pp_t p);
    logic signed [82:0] f;
    f = (83'($signed(p.ph)) <<< 24) + 83'($signed(p.pl));
    return 52'(f >>> 30);
  endfunction

  // shift the normalizer by sh when the top sh bits are still clear
  function automatic pipe_t norm_step(input pipe_t s, input int sh);
    pipe_t r;
    r = s;
    if ((s.nm >> (61 - sh)) == 61'd0) begin
      r.nm     = s.nm << sh;
      r.cord_x = s.cord_x <<< sh;
      r.cord_y = s.cord_y <<< sh;
    end
    return r;
  endfunction

  // round half up from q30.24 to q16.16, saturate; bit 32 flags a clamp
  function automatic logic [32:0] to_pixel(input logic signed [53:0] q);
    logic signed [54:0] r;
    r = (55'(q) + 55'sd128) >>> 8;
    if ((&r[54:31]) || !(|r[54:31])) begin
      return {1'b0, r[31:0]};
    end
    return {1'b1, r[54] ? 32'h8000_0000 : 32'h7FFF_FFFF};
  endfunction

endpackage

// ===== hw/rtl/fisheye_ray_to_pixel_projection_core.sv =====
// ----------------------------------------------------------------------------
// fisheye_ray_to_pixel_projection_core
// Throughput: one request per cycle while no result stalls; the pipeline
// holds the 32-step root, the 30-step cordic and two stages per polynomial
// term, all fully pipelined.
// A stalled result freezes the whole pipeline. Reset clears the valid bits and
// resets the config registers; stage data and coefficient table hold no reset value.
// ----------------------------------------------------------------------------
module fisheye_ray_to_pixel_projection_core
  import frp_pkg::*;
#(
  parameter int MAX_TERMS = MAX_TERMS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CNT_W  = $clog2(MAX_TERMS + 1);
  localparam int K_HEND = K_HORN0 + 2 * MAX_TERMS;
  localparam int K_PX   = K_HEND;
  localparam int K_PJ   = K_HEND + 1;
  localparam int K_AF   = K_HEND + 2;
  localparam int K_AJ   = K_HEND + 3;
  localparam int K_OUT  = K_HEND + 4;
  localparam int STAGES = K_OUT + 1;

  cfg_t               cfg_r;
  logic [4:0]         term_count_r;
  logic [CNT_W-1:0]   cnt_c;
  logic signed [47:0] coef_r [MAX_TERMS];
  pipe_t              st_r [STAGES];
  pipe_t              st0_c;
  logic [STAGES-1:0]  valid_r;
  logic               en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_x <= '0;
      cfg_r.center_y <= '0;
      cfg_r.affine_c <= 32'sh4000_0000;
      cfg_r.affine_d <= '0;
      cfg_r.affine_e <= '0;
      term_count_r   <= 5'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTER_X:   cfg_r.center_x <= $signed(cfg_wdata);
        REG_CENTER_Y:   cfg_r.center_y <= $signed(cfg_wdata);
        REG_AFFINE_C:   cfg_r.affine_c <= $signed(cfg_wdata);
        REG_AFFINE_D:   cfg_r.affine_d <= $signed(cfg_wdata);
        REG_AFFINE_E:   cfg_r.affine_e <= $signed(cfg_wdata);
        REG_TERM_COUNT: term_count_r   <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (term_count_r == 5'd0) begin
      cnt_c = CNT_W'(1);
    end else if (32'(term_count_r) > MAX_TERMS) begin
      cnt_c = CNT_W'(MAX_TERMS);
    end else begin
      cnt_c = CNT_W'(term_count_r);
    end
  end

  function automatic pipe_t stage_fn(input pipe_t si, input int k,
                                     input logic signed [47:0] coef,
                                     input logic hload, input logic hstep,
                                     input cfg_t cfg);
    pipe_t              s;
    logic signed [63:0] sq;
    logic [35:0]        rem_t;
    logic [35:0]        trial;
    logic [31:0]        az;
    logic [31:0]        ax;
    logic [31:0]        ay;
    logic [31:0]        m;
    logic signed [63:0] dx;
    logic signed [63:0] dy;
    logic [61:0]        dcmp;
    logic signed [52:0] hsum;
    logic [32:0]        pu;
    logic [32:0]        pv;
    s = si;
    if (k == K_SQ) begin
      sq   = si.item.ray_x * si.item.ray_x;
      s.xx = sq[62:0];
      sq   = si.item.ray_y * si.item.ray_y;
      s.yy = sq[62:0];
    end
    if (k == K_SUM) begin
      s.sqv   = 64'(si.xx) + 64'(si.yy);
      s.srem  = '0;
      s.sroot = '0;
    end
    // integer square root, one result bit per stage
    if (k >= K_SQRT0 && k < K_SQRT0 + SQRT_STEPS) begin
      rem_t = {si.srem[33:0], si.sqv[63:62]};
      trial = {2'b00, si.sroot, 2'b01};
      s.sqv = si.sqv << 2;
      if (rem_t >= trial) begin
        s.srem  = rem_t - trial;
        s.sroot = {si.sroot[30:0], 1'b1};
      end else begin
        s.srem  = rem_t;
        s.sroot = {si.sroot[30:0], 1'b0};
      end
    end
    if (k == K_PREP) begin
      az       = si.item.ray_z[31] ? 32'(-si.item.ray_z) : 32'(si.item.ray_z);
      ax       = si.item.ray_x[31] ? 32'(-si.item.ray_x) : 32'(si.item.ray_x);
      ay       = si.item.ray_y[31] ? 32'(-si.item.ray_y) : 32'(si.item.ray_y);
      m        = (si.sroot > az) ? si.sroot : az;
      s.nm     = 61'(m) << 28;
      s.cord_x = $signed({32'd0, si.sroot} << 28);
      s.cord_y = $signed({32'd0, az} << 28);
      s.ang    = '0;
      s.drx    = 62'(ax) << 30;
      s.dry    = 62'(ay) << 30;
      s.qx     = '0;
      s.qy     = '0;
    end
    if (k == K_NORM0) begin
      s = norm_step(s, 32);
      s = norm_step(s, 16);
    end
    if (k == K_NORM0 + 1) begin
      s = norm_step(s, 8);
      s = norm_step(s, 4);
    end
    if (k == K_NORM0 + 2) begin
      s = norm_step(s, 2);
      s = norm_step(s, 1);
    end
    if (k >= K_CORD0 && k < K_CORD0 + CORDIC_STEPS) begin
      dx = si.cord_y >>> (k - K_CORD0);
      dy = si.cord_x >>> (k - K_CORD0);
      if (!si.cord_y[63]) begin
        s.cord_x = si.cord_x + dx;
        s.cord_y = si.cord_y - dy;
        s.ang    = si.ang + atan_q30(k - K_CORD0);
      end else begin
        s.cord_x = si.cord_x - dx;
        s.cord_y = si.cord_y + dy;
        s.ang    = si.ang - atan_q30(k - K_CORD0);
      end
    end
    // restoring division of |x|, |y| scaled by 2^30 over the norm
    if (k >= K_DIV0 && k < K_DIV0 + DIV_STEPS) begin
      dcmp = 62'(si.sroot) << (DIV_STEPS - 1 - (k - K_DIV0));
      if (si.drx >= dcmp) begin
        s.drx = si.drx - dcmp;
        s.qx  = {si.qx[29:0], 1'b1};
      end else begin
        s.qx  = {si.qx[29:0], 1'b0};
      end
      if (si.dry >= dcmp) begin
        s.dry = si.dry - dcmp;
        s.qy  = {si.qy[29:0], 1'b1};
      end else begin
        s.qy  = {si.qy[29:0], 1'b0};
      end
    end
    if (k == K_DSGN) begin
      s.ux = si.item.ray_x[31] ? -$signed({1'b0, si.qx}) : $signed({1'b0, si.qx});
      s.uy = si.item.ray_y[31] ? -$signed({1'b0, si.qy}) : $signed({1'b0, si.qy});
    end
    if (k == K_THETA) begin
      s.theta = si.item.ray_z[31] ? -si.ang : si.ang;
      s.rho   = '0;
      s.clip  = 1'b0;
    end
    // horner: slot for the highest coefficient first, two stages per slot
    if (k >= K_HORN0 && k < K_HEND) begin
      if (((k - K_HORN0) & 1) == 0) begin
        s.p0 = mul_split(50'(si.rho), si.theta);
      end else if (hstep) begin
        hsum = 53'(mul_join(si.p0)) + 53'(coef);
        if ((&hsum[52:47]) || !(|hsum[52:47])) begin
          s.rho = hsum[47:0];
        end else begin
          s.rho  = hsum[52] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
          s.clip = 1'b1;
        end
      end else if (hload) begin
        s.rho = coef;
      end
    end
    if (k == K_PX) begin
      s.p0 = mul_split(50'(si.rho), si.ux);
      s.p1 = mul_split(50'(si.rho), si.uy);
    end
    if (k == K_PJ) begin
      s.px = 50'(mul_join(si.p0));
      s.py = 50'(mul_join(si.p1));
    end
    if (k == K_AF) begin
      s.p0 = mul_split(si.px, cfg.affine_c);
      s.p1 = mul_split(si.py, cfg.affine_d);
      s.p2 = mul_split(si.px, cfg.affine_e);
    end
    if (k == K_AJ) begin
      s.su = 54'(mul_join(si.p0)) + 54'(mul_join(si.p1)) + (54'(cfg.center_x) <<< 8);
      s.sv = 54'(mul_join(si.p2)) + 54'(si.py) + (54'(cfg.center_y) <<< 8);
    end
    if (k == K_OUT) begin
      pu = to_pixel(si.su);
      pv = to_pixel(si.sv);
      if (si.on_axis) begin
        s.res.pixel_u = cfg.center_x;
        s.res.pixel_v = cfg.center_y;
        s.res.on_axis = 1'b1;
        s.res.clipped = 1'b0;
      end else begin
        s.res.pixel_u = $signed(pu[31:0]);
        s.res.pixel_v = $signed(pv[31:0]);
        s.res.on_axis = 1'b0;
        s.res.clipped = si.clip | pu[32] | pv[32];
      end
    end
    return s;
  endfunction

  assign out_valid = valid_r[STAGES-1] && (st_r[STAGES-1].item.cmd == CMD_RAY);
  assign out_data  = st_r[STAGES-1].res;
  assign en        = !(out_valid && !out_ready);
  assign in_ready  = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[STAGES-2:0], in_valid};
    end
  end

  always_comb begin
    st0_c         = '0;
    st0_c.item    = in_data;
    st0_c.on_axis = (in_data.ray_x == 32'sd0) && (in_data.ray_y == 32'sd0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= st0_c;
    end
  end

  for (genvar k = 1; k < STAGES; k++) begin : g_stage
    localparam int SLOT = (k >= K_HORN0 && k < K_HEND) ?
                          (MAX_TERMS - 1 - (k - K_HORN0) / 2) : 0;
    logic hload;
    logic hstep;
    assign hload = (cnt_c == CNT_W'(SLOT + 1));
    assign hstep = (cnt_c > CNT_W'(SLOT + 1));
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k] <= stage_fn(st_r[k-1], k, coef_r[SLOT], hload, hstep, cfg_r);
      end
    end
  end

  // each coefficient is written where its horner slot reads it, keeping order
  for (genvar i = 0; i < MAX_TERMS; i++) begin : g_coef
    localparam int KW = K_HORN0 + 2 * (MAX_TERMS - 1 - i) + 1;
    always_ff @(posedge clk) begin
      if (en && valid_r[KW-1] && (st_r[KW-1].item.cmd == CMD_COEF) &&
          (32'(st_r[KW-1].item.coef_index) == i)) begin
        coef_r[i] <= st_r[KW-1].item.coef_value;
      end
    end
  end

`ifndef SYNTHESIS
  a_stall_holds_valid: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(valid_r)) else $error("valid bits moved during a stall");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> valid_r[0]) else $error("accepted request lost");

  a_axis_not_clipped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.on_axis) |-> !out_data.clipped)
    else $error("on-axis result flagged as clipped");

  a_quotient_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r[K_DSGN-1] && (st_r[K_DSGN-1].item.cmd == CMD_RAY) &&
     !st_r[K_DSGN-1].on_axis) |->
    ((st_r[K_DSGN-1].qx <= 31'h4000_0000) && (st_r[K_DSGN-1].qy <= 31'h4000_0000)))
    else $error("unit direction exceeds one");
`endif

endmodule
